// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine: command codes,
// pin step numbers of each command sequence, and the tick and state records.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd10;

    // Step numbers; zero means idle
    localparam logic [3:0] STEP_IDLE  = 4'd0;
    localparam logic [3:0] STEP_FIRST = 4'd1;

    // Start sequence
    localparam logic [3:0] ST_SCL_REL = 4'd1;
    localparam logic [3:0] ST_LAST    = 4'd2;

    // Stop sequence
    localparam logic [3:0] SP_SDA_LOW = 4'd1;
    localparam logic [3:0] SP_SCL_REL = 4'd2;
    localparam logic [3:0] SP_LAST    = 4'd3;

    // Write sequence
    localparam logic [3:0] WR_SCL_LOW     = 4'd1;
    localparam logic [3:0] WR_SDA_BIT     = 4'd2;
    localparam logic [3:0] WR_SCL_REL     = 4'd3;
    localparam logic [3:0] WR_WAIT        = 4'd4;
    localparam logic [3:0] WR_ACK_SCL_LOW = 4'd5;
    localparam logic [3:0] WR_ACK_SDA_REL = 4'd6;
    localparam logic [3:0] WR_ACK_SCL_REL = 4'd7;
    localparam logic [3:0] WR_END_SCL_LOW = 4'd8;

    // Read sequence
    localparam logic [3:0] RD_SCL_LOW     = 4'd1;
    localparam logic [3:0] RD_SCL_REL     = 4'd2;
    localparam logic [3:0] RD_WAIT        = 4'd3;
    localparam logic [3:0] RD_ACK_SCL_LOW = 4'd4;
    localparam logic [3:0] RD_ACK_SDA     = 4'd5;
    localparam logic [3:0] RD_ACK_SCL_REL = 4'd6;
    localparam logic [3:0] RD_END_SCL_LOW = 4'd7;

    // One tick as it enters the engine
    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } t_item;

    // Engine state; the drive and status fields are also the result
    typedef struct packed {
        logic [3:0] step;
        logic [7:0] tick;
        logic [3:0] bit_cnt;
        logic [7:0] shift;
        logic [1:0] cmd;
        logic       ack_choice;
        logic       scl_drive;
        logic       sda_drive;
        logic       ack_flag;
        logic [7:0] rx_hold;
    } t_state;

    // Last step of each command sequence
    function automatic logic [3:0] last_step(input logic [1:0] cmd);
        logic [3:0] last;
        case (cmd)
            CMD_START: last = ST_LAST;
            CMD_STOP:  last = SP_LAST;
            CMD_WRITE: last = WR_END_SCL_LOW;
            default:   last = RD_END_SCL_LOW;
        endcase
        return last;
    endfunction

endpackage

// File: rtl/i2cm_in_reg.sv
// ----------------------------------------------------------------------------
// i2cm_in_reg
// Input register: holds one tick until the engine takes it.
// ----------------------------------------------------------------------------
module i2cm_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  i2cm_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output i2cm_pkg::t_item o_item
);

    logic            r_valid;
    i2cm_pkg::t_item r_item;

    // Accept when empty or when the held tick leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on each transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/i2cm_step_logic.sv
// ----------------------------------------------------------------------------
// i2cm_step_logic
// Next-state logic for one tick: command pickup, delay and SCL wait phases,
// bit shifting, ack sampling and the pin action of each entered step.
// ----------------------------------------------------------------------------
module i2cm_step_logic (
    input  i2cm_pkg::t_state i_state,
    input  i2cm_pkg::t_item  i_item,
    input  logic [7:0]       i_phase_ticks,
    output i2cm_pkg::t_state o_state,
    output logic             o_done
);

    always_comb begin
        i2cm_pkg::t_state n_st;
        logic             enter;
        logic             in_wait;
        logic [3:0]       tgt;
        logic [3:0]       bit_inc;
        logic [7:0]       tick_inc;
        logic [7:0]       limit;

        n_st     = i_state;
        enter    = 1'b0;
        tgt      = i2cm_pkg::STEP_IDLE;
        o_done   = 1'b0;
        bit_inc  = i_state.bit_cnt + 4'd1;
        tick_inc = i_state.tick + 8'd1;
        limit    = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
        in_wait  = (i_state.cmd == i2cm_pkg::CMD_WRITE && i_state.step == i2cm_pkg::WR_WAIT) ||
                   (i_state.cmd == i2cm_pkg::CMD_READ && i_state.step == i2cm_pkg::RD_WAIT);

        // Advance the phase
        if (i_state.step == i2cm_pkg::STEP_IDLE) begin
            if (i_item.cmd_valid) begin
                n_st.cmd        = i_item.req_type;
                n_st.shift      = (i_item.req_type == i2cm_pkg::CMD_WRITE) ?
                                  i_item.tx_byte : 8'd0;
                n_st.ack_choice = i_item.send_ack;
                n_st.bit_cnt    = 4'd0;
                enter           = 1'b1;
                tgt             = i2cm_pkg::STEP_FIRST;
            end
        end else if (in_wait) begin
            if (i_item.scl_in) begin
                if (i_state.cmd == i2cm_pkg::CMD_READ) begin
                    n_st.shift = {i_state.shift[6:0], i_item.sda_in};
                end else begin
                    n_st.shift = {i_state.shift[6:0], 1'b0};
                end
                n_st.bit_cnt = bit_inc;
                enter        = 1'b1;
                tgt          = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                               (i_state.step + 4'd1) : i2cm_pkg::STEP_FIRST;
            end
        end else begin
            n_st.tick = tick_inc;
            if (tick_inc >= limit) begin
                if (i_state.cmd == i2cm_pkg::CMD_WRITE &&
                    i_state.step == i2cm_pkg::WR_ACK_SCL_REL) begin
                    n_st.ack_flag = !i_item.sda_in;
                end
                enter = 1'b1;
                tgt   = i_state.step + 4'd1;
            end
        end

        // Enter the next step: finish or apply its pin action
        if (enter) begin
            n_st.step = tgt;
            n_st.tick = 8'd0;
            if (tgt > i2cm_pkg::last_step(n_st.cmd)) begin
                if (n_st.cmd == i2cm_pkg::CMD_READ) begin
                    n_st.sda_drive = 1'b0;
                    n_st.rx_hold   = n_st.shift;
                end
                n_st.step = i2cm_pkg::STEP_IDLE;
                o_done    = 1'b1;
            end else begin
                case (n_st.cmd)
                    i2cm_pkg::CMD_START: begin
                        if (tgt == i2cm_pkg::ST_SCL_REL) begin
                            n_st.scl_drive = 1'b0;
                        end else begin
                            n_st.sda_drive = 1'b1;
                        end
                    end
                    i2cm_pkg::CMD_STOP: begin
                        if (tgt == i2cm_pkg::SP_SDA_LOW) begin
                            n_st.sda_drive = 1'b1;
                        end else if (tgt == i2cm_pkg::SP_SCL_REL) begin
                            n_st.scl_drive = 1'b0;
                        end else begin
                            n_st.sda_drive = 1'b0;
                        end
                    end
                    i2cm_pkg::CMD_WRITE: begin
                        case (tgt)
                            i2cm_pkg::WR_SCL_LOW:     n_st.scl_drive = 1'b1;
                            i2cm_pkg::WR_SDA_BIT:     n_st.sda_drive = !n_st.shift[7];
                            i2cm_pkg::WR_SCL_REL:     n_st.scl_drive = 1'b0;
                            i2cm_pkg::WR_ACK_SCL_LOW: n_st.scl_drive = 1'b1;
                            i2cm_pkg::WR_ACK_SDA_REL: n_st.sda_drive = 1'b0;
                            i2cm_pkg::WR_ACK_SCL_REL: n_st.scl_drive = 1'b0;
                            i2cm_pkg::WR_END_SCL_LOW: n_st.scl_drive = 1'b1;
                            default: ;
                        endcase
                    end
                    default: begin
                        case (tgt)
                            i2cm_pkg::RD_SCL_LOW:     n_st.scl_drive = 1'b1;
                            i2cm_pkg::RD_SCL_REL:     n_st.scl_drive = 1'b0;
                            i2cm_pkg::RD_ACK_SCL_LOW: n_st.scl_drive = 1'b1;
                            i2cm_pkg::RD_ACK_SDA:     n_st.sda_drive = n_st.ack_choice;
                            i2cm_pkg::RD_ACK_SCL_REL: n_st.scl_drive = 1'b0;
                            i2cm_pkg::RD_END_SCL_LOW: n_st.scl_drive = 1'b1;
                            default: ;
                        endcase
                    end
                endcase
            end
        end

        o_state = n_st;
    end

endmodule

// File: rtl/i2c_master_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Open-drain I2C master byte engine, one input transfer per bus timing tick.
// ----------------------------------------------------------------------------
// Each input transfer is one tick carrying the sampled SCL/SDA levels and an
// optional command (start, stop, write byte, read byte), taken only while
// idle. Every tick yields exactly one result transfer with the pin drives
// and status after that tick. The engine takes one tick per clock cycle
// when the result side keeps up; a tick is registered in the input register
// and then in the state register, which also serves as the result register.
// Delay phases last phase_ticks ticks (zero counts as one); after each data-bit
// SCL release the engine waits, with no timeout, for SCL to read high.
module i2c_master_byte_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_phase_ticks,
    // tick input
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd_valid,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_scl_in,
    input  logic       i_sda_in,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_pull_low,
    output logic       o_sda_pull_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_data,
    output logic       o_ack_seen
);

    logic [7:0]       r_phase_ticks;
    i2cm_pkg::t_item  in_item;
    i2cm_pkg::t_item  s1_item;
    logic             s1_valid;
    logic             advance;
    i2cm_pkg::t_state r_state;
    i2cm_pkg::t_state n_state;
    logic             n_done;
    logic             r_done;
    logic             r_out_valid;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
        end else if (i_cfg_valid) begin
            r_phase_ticks <= i_cfg_phase_ticks;
        end
    end

    // Input register
    assign in_item = '{cmd_valid: i_cmd_valid, req_type: i_req_type, tx_byte: i_tx_byte,
                       send_ack: i_send_ack, scl_in: i_scl_in, sda_in: i_sda_in};

    i2cm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (s1_valid),
        .i_take  (advance),
        .o_item  (s1_item)
    );

    // Step a tick when the result slot is free or being drained
    assign advance = s1_valid && (!r_out_valid || i_out_ready);

    i2cm_step_logic u_step (
        .i_state       (r_state),
        .i_item        (s1_item),
        .i_phase_ticks (r_phase_ticks),
        .o_state       (n_state),
        .o_done        (n_done)
    );

    // Hold state and result; update only on a stepped tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
                r_done  <= n_done;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_pull_low = r_state.scl_drive;
    assign o_sda_pull_low = r_state.sda_drive;
    assign o_busy_res     = (r_state.step != i2cm_pkg::STEP_IDLE);
    assign o_done_res     = r_done;
    assign o_rx_data      = r_state.rx_hold;
    assign o_ack_seen     = r_state.ack_flag;

endmodule

// File: rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_pull_low,
    input logic       o_sda_pull_low,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_data,
    input logic       o_ack_seen
);

    // A completed sequence leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while busy");

    // Done is a single-tick pulse across consecutive results
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_done_res |=> !(o_out_valid && o_done_res))
        else $error("done asserted on two consecutive results");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_scl_pull_low) &&
        $stable(o_sda_pull_low) && $stable(o_rx_data) && $stable(o_ack_seen))
        else $error("stalled result changed");

    // Reset empties the result slot and releases both lines
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_scl_pull_low && !o_sda_pull_low)
        else $error("reset did not clear outputs");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_scl_pull_low (o_scl_pull_low),
    .o_sda_pull_low (o_sda_pull_low),
    .o_busy_res     (o_busy_res),
    .o_done_res     (o_done_res),
    .o_rx_data      (o_rx_data),
    .o_ack_seen     (o_ack_seen)
);
